// File: rtl/tte_pkg.sv
// Shared types, constants and helper functions for the text terminal engine.
// No dependencies; every other file imports this package.
package tte_pkg;

   localparam int ROWS     = 25;
   localparam int COLUMNS  = 80;
   localparam int SCREENS  = 4;
   localparam int TAB_STOP = 8;

   localparam int CELLS       = ROWS * COLUMNS;
   localparam int TOTAL_CELLS = SCREENS * CELLS;
   localparam int COPY_CELLS  = (ROWS - 1) * COLUMNS;
   localparam int BOTTOM_BASE = (ROWS - 1) * COLUMNS;

   localparam int RW   = $clog2(ROWS);
   localparam int CW   = $clog2(COLUMNS);
   localparam int TCW  = $clog2(COLUMNS + TAB_STOP);
   localparam int SW   = (SCREENS > 1) ? $clog2(SCREENS) : 1;
   localparam int PW   = $clog2(CELLS);
   localparam int AW   = $clog2(TOTAL_CELLS);
   localparam int CNTW = $clog2(TOTAL_CELLS + 1);

   localparam logic [2:0] MODE_PUT    = 3'd0;
   localparam logic [2:0] MODE_COLOR  = 3'd1;
   localparam logic [2:0] MODE_CLEAR  = 3'd2;
   localparam logic [2:0] MODE_SWITCH = 3'd3;
   localparam logic [2:0] MODE_READ   = 3'd4;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_GT    = 8'h3E;

   localparam logic [7:0]  RESET_COLOR = 8'h07;
   localparam logic [15:0] RESET_CELL  = 16'h0720;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  char_code;
      logic [7:0]  color_value;
      logic [1:0]  screen_select;
      logic [10:0] cell_index;
   } req_type;

   typedef struct packed {
      logic [10:0] cursor_position;
      logic [1:0]  active_screen;
      logic [15:0] cell_data;
      logic        scrolled;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NOP, OP_LOAD, OP_INIT, OP_PUT, OP_COPY, OP_BLANK,
      OP_CLEAR, OP_COLOR, OP_SWITCH, OP_READ, OP_CAPTURE
   } op_type;

   typedef enum logic [1:0] {
      CH_REQ, CH_GT, CH_SP
   } chr_sel_type;

   typedef struct packed {
      op_type      op;
      chr_sel_type chr_sel;
   } cmd_type;

   typedef struct packed {
      logic       sweep_last;
      logic       need_scroll;
      logic       need_prompt;
      logic [2:0] mode;
   } status_type;

   // next tab stop strictly after col
   function automatic logic [TCW-1:0] tab_target(input logic [CW-1:0] col);
      logic [TCW-1:0] r;
      r = '0;
      for (int k = 1; k <= COLUMNS / TAB_STOP + 1; k++) begin
         if ((k * TAB_STOP > int'(col)) && ((k - 1) * TAB_STOP <= int'(col))) begin
            r = TCW'(k * TAB_STOP);
         end
      end
      return r;
   endfunction

endpackage

// File: rtl/tte_datapath.sv
// Datapath: cell memory, per-screen cursor/color/prompt state, sweep counter.
// Depends on tte_pkg; driven by commands from tte_controller.
module tte_datapath import tte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   input  req_type    req_data,
   output status_type status,
   output rsp_type    rsp_data
);

   logic [15:0]   cell_mem_ff [TOTAL_CELLS];
   logic [15:0]   rdata_ff;

   req_type       req_ff;
   logic [SW-1:0] cur_ff;
   logic [RW-1:0] row_ff [SCREENS];
   logic [CW-1:0] col_ff [SCREENS];
   logic [7:0]    color_ff [SCREENS];
   logic          prompt_ff [SCREENS];
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic          scrolled_ff;
   logic [15:0]   data_ff;

   logic [RW-1:0] row, row_in;
   logic [CW-1:0] col, col_in;
   logic [7:0]    color, ch;
   logic          cursor_we;
   logic [AW-1:0] base;
   logic [PW-1:0] pos, pos_new;
   logic [TCW-1:0] tgt;
   logic          is_lf, is_tab, is_bs, is_print, nl, scroll;
   logic          mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0]   mem_wdata;
   logic [SW-1:0] sel;
   logic          sel_ok;
   logic          idx_ok;
   logic          sweep_last;

   assign row   = row_ff[cur_ff];
   assign col   = col_ff[cur_ff];
   assign color = color_ff[cur_ff];
   assign base  = AW'(cur_ff) * AW'(CELLS);
   assign pos   = PW'(row) * PW'(COLUMNS) + PW'(col);
   assign sel   = SW'(req_ff.screen_select);
   assign sel_ok = int'(req_ff.screen_select) < SCREENS;
   assign idx_ok = int'(req_ff.cell_index) < CELLS;

   always_comb begin
      unique case (cmd.chr_sel)
         CH_GT:   ch = CHAR_GT;
         CH_SP:   ch = CHAR_SPACE;
         default: ch = req_ff.char_code;
      endcase
   end

   // put-character cursor update
   always_comb begin
      is_lf    = ch == CHAR_LF;
      is_tab   = ch == CHAR_TAB;
      is_bs    = ch == CHAR_BS;
      is_print = !is_lf && !is_tab && !is_bs;
      tgt      = tab_target(col);
      nl       = is_lf || (is_tab && int'(tgt) >= COLUMNS)
                 || (is_print && int'(col) == COLUMNS - 1);
      scroll   = nl && int'(row) == ROWS - 1;
      row_in   = row;
      col_in   = col;
      if (nl) begin
         col_in = '0;
         if (!scroll) row_in = row + RW'(1);
      end else if (is_tab) begin
         col_in = CW'(tgt);
      end else if (is_bs) begin
         if (col != '0) begin
            col_in = col - CW'(1);
         end else if (row != '0) begin
            row_in = row - RW'(1);
            col_in = CW'(COLUMNS - 1);
         end
      end else begin
         col_in = col + CW'(1);
      end
      pos_new = PW'(row_in) * PW'(COLUMNS) + PW'(col_in);
   end

   // memory port selection and sweep counter; the counter rests at zero
   // outside a sweep
   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wdata  = {color, CHAR_SPACE};
      mem_raddr  = base + AW'(req_ff.cell_index);
      cnt_in     = '0;
      sweep_last = 1'b0;
      cursor_we  = 1'b0;
      unique case (cmd.op)
         OP_LOAD: cnt_in = '0;
         OP_INIT: begin
            mem_we     = 1'b1;
            mem_waddr  = AW'(cnt_ff);
            mem_wdata  = RESET_CELL;
            cnt_in     = cnt_ff + CNTW'(1);
            sweep_last = int'(cnt_ff) == TOTAL_CELLS - 1;
         end
         OP_PUT: begin
            cursor_we = 1'b1;
            cnt_in    = '0;
            if (is_bs) begin
               mem_we    = 1'b1;
               mem_waddr = base + AW'(pos_new);
            end else if (is_print) begin
               mem_we    = 1'b1;
               mem_waddr = base + AW'(pos);
               mem_wdata = {color, ch};
            end
         end
         OP_COPY: begin
            // read one row ahead, write the registered word in the next cycle
            mem_raddr  = base + AW'(cnt_ff) + AW'(COLUMNS);
            mem_we     = cnt_ff != '0;
            mem_waddr  = base + AW'(cnt_ff - CNTW'(1));
            mem_wdata  = rdata_ff;
            cnt_in     = cnt_ff + CNTW'(1);
            sweep_last = int'(cnt_ff) == COPY_CELLS;
         end
         OP_BLANK: begin
            mem_we     = 1'b1;
            mem_waddr  = base + AW'(BOTTOM_BASE) + AW'(cnt_ff);
            cnt_in     = cnt_ff + CNTW'(1);
            sweep_last = int'(cnt_ff) == COLUMNS - 1;
         end
         OP_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = base + AW'(cnt_ff);
            cnt_in     = cnt_ff + CNTW'(1);
            sweep_last = int'(cnt_ff) == CELLS - 1;
         end
         default: ;
      endcase
      if (sweep_last) cnt_in = '0;
   end

   assign status.sweep_last  = sweep_last;
   assign status.need_scroll = scroll;
   assign status.need_prompt = sel_ok && !prompt_ff[sel];
   assign status.mode        = req_ff.mode;

   always_ff @(posedge clock) begin
      if (mem_we) cell_mem_ff[mem_waddr] <= mem_wdata;
      rdata_ff <= cell_mem_ff[mem_raddr];
      if (cmd.op == OP_LOAD) req_ff <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= '0;
         cnt_ff      <= '0;
         scrolled_ff <= 1'b0;
         data_ff     <= '0;
         for (int i = 0; i < SCREENS; i++) begin
            row_ff[i]    <= '0;
            col_ff[i]    <= '0;
            color_ff[i]  <= RESET_COLOR;
            prompt_ff[i] <= (i == 0);
         end
      end else begin
         cnt_ff <= cnt_in;
         if (cmd.op == OP_LOAD) begin
            scrolled_ff <= 1'b0;
            data_ff     <= '0;
         end
         if (cursor_we) begin
            row_ff[cur_ff] <= row_in;
            col_ff[cur_ff] <= col_in;
            if (scroll) scrolled_ff <= 1'b1;
         end
         if (cmd.op == OP_COLOR) color_ff[cur_ff] <= req_ff.color_value;
         if (cmd.op == OP_CLEAR && sweep_last) begin
            row_ff[cur_ff] <= '0;
            col_ff[cur_ff] <= '0;
         end
         if (cmd.op == OP_SWITCH && sel_ok) begin
            cur_ff         <= sel;
            prompt_ff[sel] <= 1'b1;
         end
         if (cmd.op == OP_CAPTURE && idx_ok) data_ff <= rdata_ff;
      end
   end

   assign rsp_data.cursor_position = 11'(pos);
   assign rsp_data.active_screen   = 2'(cur_ff);
   assign rsp_data.cell_data       = data_ff;
   assign rsp_data.scrolled        = scrolled_ff;

endmodule

// File: rtl/tte_controller.sv
// Sequencer for the terminal engine: handshakes, mode decode, sweeps.
// Depends on tte_pkg; commands tte_datapath.
module tte_controller import tte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_DECODE, ST_PROMPT1, ST_PROMPT2, ST_COPY,
      ST_BLANK, ST_CLEAR, ST_CAPTURE, ST_RESP
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      cmd.op      = OP_NOP;
      cmd.chr_sel = CH_REQ;
      unique case (state_ff)
         ST_INIT: begin
            cmd.op = OP_INIT;
            if (status.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_RESP;
            unique case (status.mode)
               MODE_PUT: begin
                  cmd.op = OP_PUT;
                  if (status.need_scroll) begin
                     state_in = ST_COPY;
                     ret_in   = ST_RESP;
                  end
               end
               MODE_COLOR: cmd.op = OP_COLOR;
               MODE_CLEAR: state_in = ST_CLEAR;
               MODE_SWITCH: begin
                  cmd.op = OP_SWITCH;
                  if (status.need_prompt) state_in = ST_PROMPT1;
               end
               MODE_READ: begin
                  cmd.op   = OP_READ;
                  state_in = ST_CAPTURE;
               end
               default: ;
            endcase
         end
         ST_PROMPT1: begin
            cmd.op      = OP_PUT;
            cmd.chr_sel = CH_GT;
            state_in    = ST_PROMPT2;
            if (status.need_scroll) begin
               state_in = ST_COPY;
               ret_in   = ST_PROMPT2;
            end
         end
         ST_PROMPT2: begin
            cmd.op      = OP_PUT;
            cmd.chr_sel = CH_SP;
            state_in    = ST_RESP;
            if (status.need_scroll) begin
               state_in = ST_COPY;
               ret_in   = ST_RESP;
            end
         end
         ST_COPY: begin
            cmd.op = OP_COPY;
            if (status.sweep_last) state_in = ST_BLANK;
         end
         ST_BLANK: begin
            cmd.op = OP_BLANK;
            if (status.sweep_last) state_in = ret_ff;
         end
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (status.sweep_last) state_in = ST_RESP;
         end
         ST_CAPTURE: begin
            cmd.op   = OP_CAPTURE;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         ret_ff   <= ST_RESP;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = state_ff == ST_RESP;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response open at once");

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken before response");

   a_resp_after_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped before taken");

   a_sweep_not_ready: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_COPY || cmd.op == OP_CLEAR || cmd.op == OP_INIT) |-> !req_ready)
      else $error("request port open during sweep");

endmodule

// File: rtl/text_terminal_engine.sv
// Text terminal engine: one response per request, always giving the active
// cursor position and screen. After reset a clearing pass writes every cell
// of all screens, one cell per cycle (SCREENS*ROWS*COLUMNS = 8000 cells),
// before the first request is taken. Clear screen walks ROWS*COLUMNS cells,
// and a put character that scrolls copies (ROWS-1)*COLUMNS cells up one row
// and blanks the COLUMNS cells of the bottom row through the
// single-write-port cell memory.
module text_terminal_engine import tte_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   tte_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tte_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
